/* design/command_admission_tick_batcher_macros.svh */
// Assertion helpers used by catb_dp.
`ifndef COMMAND_ADMISSION_TICK_BATCHER_MACROS_SVH
`define COMMAND_ADMISSION_TICK_BATCHER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define CATB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("catb assertion failed");

// Next-cycle implication.
`define CATB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("catb assertion failed");

`endif

/* design/catb_pkg.sv */
package catb_pkg;

    localparam int Q_DEPTH   = 32;
    localparam int Q_AW      = $clog2(Q_DEPTH);
    localparam int Q_FW      = $clog2(Q_DEPTH + 1);
    localparam int MAX_TICKS = 16;

    localparam logic [1:0] RK_STATUS = 2'd0;
    localparam logic [1:0] RK_CMD    = 2'd1;
    localparam logic [1:0] RK_EMPTY  = 2'd2;
    localparam logic [1:0] RK_END    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_SESS   = 2'd1;
    localparam logic [1:0] ST_GLOBAL = 2'd2;
    localparam logic [1:0] ST_TERM   = 2'd3;

    localparam logic [2:0] FLT_NONE  = 3'd0;
    localparam logic [2:0] FLT_ORD   = 3'd4;

    localparam logic [1:0] CFG_SLIM  = 2'd0;
    localparam logic [1:0] CFG_GLIM  = 2'd1;
    localparam logic [1:0] CFG_BUD   = 2'd2;
    localparam logic [1:0] CFG_START = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SCAN,
        OP_SUB,
        OP_ADMIT,
        OP_CHECK,
        OP_PEND,
        OP_EMPTY,
        OP_NEXT,
        OP_CRD,
        OP_CMD
    } t_op;

    typedef struct packed {
        logic scan_done;
        logic fault_nz;
        logic sf_nz;
        logic ticks_zero;
        logic short_ord;
        logic t_end;
        logic inb_zero;
        logic batch_none;
        logic batch_full;
        logic out_free;
    } t_sts;

endpackage

/* design/command_admission_tick_batcher.sv */
// Submit: the queue is scanned with one entry compared per cycle (one RAM read port).
// Pump: budget and ordinal check, tick loop draining the queue, end result; no ticks on early end.
// One item in flight; the next item is taken once the last result sits in the output register.
// Reset (synchronous, active low): queue empty, no fault, config registers back to defaults,
// ordinal counter at zero; queue RAM contents are not cleared.
module command_admission_tick_batcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    // input items
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [31:0] i_session_id,
    input  logic [31:0] i_session_generation,
    input  logic [31:0] i_command_tag,
    input  logic [4:0]  i_tick_count,
    input  logic [63:0] i_first_tick,
    input  logic [1:0]  i_scheduler_fault,
    input  logic [63:0] i_tick_lag,
    // result items
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_result_kind,
    output logic [1:0]  o_submit_status,
    output logic [63:0] o_tick_value,
    output logic [63:0] o_ordinal,
    output logic [31:0] o_out_session,
    output logic [31:0] o_out_generation,
    output logic [31:0] o_out_tag,
    output logic [2:0]  o_pump_fault,
    output logic [63:0] o_lag_out,
    output logic        o_last
);
    import catb_pkg::*;

    // controller sequences; datapath holds queue, ordinals, fault latch, output register
    t_op  op;
    t_sts sts;

    catb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_op       (op)
    );

    catb_dp u_dp (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_op                 (op),
        .o_sts                (sts),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_session_id         (i_session_id),
        .i_session_generation (i_session_generation),
        .i_command_tag        (i_command_tag),
        .i_tick_count         (i_tick_count),
        .i_first_tick         (i_first_tick),
        .i_scheduler_fault    (i_scheduler_fault),
        .i_tick_lag           (i_tick_lag),
        .i_out_stall          (i_out_stall),
        .o_out_valid          (o_out_valid),
        .o_result_kind        (o_result_kind),
        .o_submit_status      (o_submit_status),
        .o_tick_value         (o_tick_value),
        .o_ordinal            (o_ordinal),
        .o_out_session        (o_out_session),
        .o_out_generation     (o_out_generation),
        .o_out_tag            (o_out_tag),
        .o_pump_fault         (o_pump_fault),
        .o_lag_out            (o_lag_out),
        .o_last               (o_last)
    );
endmodule

/* design/catb_ram.sv */
module catb_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* design/catb_dp.sv */
module catb_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  catb_pkg::t_op        i_op,
    output catb_pkg::t_sts       o_sts,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic [31:0]          i_session_id,
    input  logic [31:0]          i_session_generation,
    input  logic [31:0]          i_command_tag,
    input  logic [4:0]           i_tick_count,
    input  logic [63:0]          i_first_tick,
    input  logic [1:0]           i_scheduler_fault,
    input  logic [63:0]          i_tick_lag,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output logic [1:0]           o_result_kind,
    output logic [1:0]           o_submit_status,
    output logic [63:0]          o_tick_value,
    output logic [63:0]          o_ordinal,
    output logic [31:0]          o_out_session,
    output logic [31:0]          o_out_generation,
    output logic [31:0]          o_out_tag,
    output logic [2:0]           o_pump_fault,
    output logic [63:0]          o_lag_out,
    output logic                 o_last
);
    import catb_pkg::*;
    `include "command_admission_tick_batcher_macros.svh"

    logic [5:0]      r_slim, r_glim, r_bud;
    logic [63:0]     r_next;
    logic            r_gone;
    logic [2:0]      r_fault;
    logic [Q_AW-1:0] r_head;
    logic [Q_FW-1:0] r_fill;
    logic [31:0]     r_sid, r_gen, r_tag;
    logic [4:0]      r_ticks;
    logic [63:0]     r_tv;
    logic [1:0]      r_sf;
    logic [63:0]     r_lag;
    logic [Q_FW-1:0] r_idx, r_cnt, r_adm, r_done;
    logic            r_pend, r_short;
    logic [4:0]      r_t;
    logic [5:0]      r_inb;

    logic            r_ov;
    logic [1:0]      r_okind, r_ostat;
    logic [63:0]     r_otick, r_oord, r_olag;
    logic [31:0]     r_osess, r_ogen, r_otag;
    logic [2:0]      r_ofault;
    logic            r_olast;

    logic            ram_we, ram_re;
    logic [Q_AW-1:0] ram_waddr, ram_raddr;
    logic [95:0]     ram_rdata;
    logic [10:0]     budget_total;
    logic            out_free, term, match, load_out;
    logic [1:0]      sub_stat;

    assign out_free     = !r_ov || !i_out_stall;
    assign term         = (r_fault != FLT_NONE) || r_gone;
    assign match        = (ram_rdata[95:64] == r_sid) && (ram_rdata[63:32] == r_gen);
    assign budget_total = 11'(r_ticks) * 11'(r_bud);

    always_comb begin
        if (term) begin
            sub_stat = ST_TERM;
        end else if (r_cnt >= Q_FW'(r_slim) || 6'(r_cnt) >= r_slim) begin
            sub_stat = ST_SESS;
        end else if (6'(r_fill) >= r_glim || r_fill >= Q_FW'(Q_DEPTH)) begin
            sub_stat = ST_GLOBAL;
        end else begin
            sub_stat = ST_OK;
        end
    end

    assign ram_we    = (i_op == OP_SUB) && (sub_stat == ST_OK);
    assign ram_waddr = r_head + r_fill[Q_AW-1:0];
    assign ram_re    = (i_op == OP_SCAN) || (i_op == OP_CRD);
    assign ram_raddr = (i_op == OP_CRD) ? r_head : r_head + r_idx[Q_AW-1:0];

    catb_ram #(.WIDTH(96), .DEPTH(Q_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_sid, r_gen, r_tag}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign load_out = (i_op == OP_SUB) || (i_op == OP_PEND) || (i_op == OP_EMPTY)
                   || (i_op == OP_CMD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slim  <= 6'd8;
            r_glim  <= 6'd32;
            r_bud   <= 6'd4;
            r_next  <= '0;
            r_gone  <= 1'b0;
            r_fault <= FLT_NONE;
            r_head  <= '0;
            r_fill  <= '0;
            r_pend  <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SLIM:  r_slim <= i_cfg_data[5:0];
                    CFG_GLIM:  r_glim <= i_cfg_data[5:0];
                    CFG_BUD:   r_bud  <= i_cfg_data[5:0];
                    CFG_START: begin
                        r_next <= i_cfg_data;
                        r_gone <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (!r_ov || !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if (load_out) begin
                r_ov     <= 1'b1;
                r_ostat  <= ST_OK;
                r_otick  <= '0;
                r_oord   <= '0;
                r_osess  <= '0;
                r_ogen   <= '0;
                r_otag   <= '0;
                r_ofault <= FLT_NONE;
                r_olag   <= '0;
                r_olast  <= 1'b0;
            end
            case (i_op)
                OP_LOAD: begin
                    r_sid   <= i_session_id;
                    r_gen   <= i_session_generation;
                    r_tag   <= i_command_tag;
                    r_ticks <= (i_tick_count > 5'(MAX_TICKS)) ? 5'(MAX_TICKS) : i_tick_count;
                    r_tv    <= i_first_tick;
                    r_sf    <= i_scheduler_fault;
                    r_lag   <= i_tick_lag;
                    r_idx   <= '0;
                    r_cnt   <= '0;
                    r_pend  <= 1'b0;
                    r_t     <= '0;
                    r_done  <= '0;
                    r_inb   <= '0;
                end
                OP_SCAN: begin
                    if (r_pend && match) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_idx < r_fill) begin
                        r_idx  <= r_idx + 1'b1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                OP_SUB: begin
                    if (term && r_fault == FLT_NONE) begin
                        r_fault <= FLT_ORD;
                    end
                    if (sub_stat == ST_OK) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_okind <= RK_STATUS;
                    r_ostat <= sub_stat;
                    r_olast <= 1'b1;
                end
                OP_ADMIT: begin
                    r_adm <= (11'(r_fill) < budget_total) ? r_fill : budget_total[Q_FW-1:0];
                end
                OP_CHECK: begin
                    r_short <= (r_adm != '0) && (r_gone ||
                               ((r_next != '0) && (64'(r_adm - 1'b1) > ~r_next)));
                end
                OP_PEND: begin
                    r_okind <= RK_END;
                    r_olast <= 1'b1;
                    if (r_fault != FLT_NONE) begin
                        r_ofault <= r_fault;
                    end else if (r_sf != 2'd0) begin
                        r_fault  <= {1'b0, r_sf};
                        r_ofault <= {1'b0, r_sf};
                        r_olag   <= r_lag;
                    end else if (r_ticks != '0 && r_short) begin
                        r_fault  <= FLT_ORD;
                        r_ofault <= FLT_ORD;
                        r_olag   <= r_lag;
                    end else begin
                        r_olag   <= r_lag;
                    end
                end
                OP_EMPTY: begin
                    r_okind <= RK_EMPTY;
                    r_otick <= r_tv;
                    r_t     <= r_t + 1'b1;
                    r_tv    <= r_tv + 64'd1;
                    r_inb   <= '0;
                end
                OP_NEXT: begin
                    r_t   <= r_t + 1'b1;
                    r_tv  <= r_tv + 64'd1;
                    r_inb <= '0;
                end
                OP_CMD: begin
                    r_okind <= RK_CMD;
                    r_otick <= r_tv;
                    r_oord  <= r_next;
                    r_osess <= ram_rdata[95:64];
                    r_ogen  <= ram_rdata[63:32];
                    r_otag  <= ram_rdata[31:0];
                    if (r_next == '1) begin
                        r_gone <= 1'b1;
                    end
                    r_next <= r_next + 64'd1;
                    r_head <= r_head + 1'b1;
                    r_fill <= r_fill - 1'b1;
                    r_done <= r_done + 1'b1;
                    r_inb  <= r_inb + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_sts.scan_done  = (r_idx >= r_fill) && !r_pend;
        o_sts.fault_nz   = (r_fault != FLT_NONE);
        o_sts.sf_nz      = (r_sf != 2'd0);
        o_sts.ticks_zero = (r_ticks == '0);
        o_sts.short_ord  = r_short;
        o_sts.t_end      = (r_t == r_ticks);
        o_sts.inb_zero   = (r_inb == '0);
        o_sts.batch_none = (r_done == r_adm) || (r_bud == '0);
        o_sts.batch_full = (r_inb == r_bud) || (r_done == r_adm);
        o_sts.out_free   = out_free;
    end

    assign o_out_valid      = r_ov;
    assign o_result_kind    = r_okind;
    assign o_submit_status  = r_ostat;
    assign o_tick_value     = r_otick;
    assign o_ordinal        = r_oord;
    assign o_out_session    = r_osess;
    assign o_out_generation = r_ogen;
    assign o_out_tag        = r_otag;
    assign o_pump_fault     = r_ofault;
    assign o_lag_out        = r_olag;
    assign o_last           = r_olast;

    `CATB_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= Q_FW'(Q_DEPTH))
    `CATB_ASSERT_IMP(a_cmd_nonempty, i_op == OP_CMD, r_fill != '0 && r_done < r_adm)
    `CATB_ASSERT_IMP(a_emit_free, load_out, out_free)
    `CATB_ASSERT_NXT(a_cmd_not_last, i_op == OP_CMD, r_ov && !r_olast)
endmodule

/* design/catb_ctrl.sv */
module catb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_kind,
    output logic           o_in_stall,
    input  catb_pkg::t_sts i_sts,
    output catb_pkg::t_op  o_op
);
    import catb_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_SUB, S_ADMIT, S_CHECK, S_PDEC, S_PEND, S_TICK, S_CRD, S_CMD
    } t_state;

    t_state r_state, n_state;
    t_op    op;

    always_comb begin
        n_state = r_state;
        op      = OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    op      = OP_LOAD;
                    n_state = i_kind ? S_ADMIT : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_SUB;
                end else begin
                    op = OP_SCAN;
                end
            end
            S_SUB: begin
                if (i_sts.out_free) begin
                    op      = OP_SUB;
                    n_state = S_IDLE;
                end
            end
            S_ADMIT: begin
                op      = OP_ADMIT;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                op      = OP_CHECK;
                n_state = S_PDEC;
            end
            S_PDEC: begin
                if (i_sts.fault_nz || i_sts.sf_nz || i_sts.ticks_zero || i_sts.short_ord) begin
                    n_state = S_PEND;
                end else begin
                    n_state = S_TICK;
                end
            end
            S_PEND: begin
                if (i_sts.out_free) begin
                    op      = OP_PEND;
                    n_state = S_IDLE;
                end
            end
            S_TICK: begin
                if (i_sts.t_end) begin
                    n_state = S_PEND;
                end else if (i_sts.inb_zero && i_sts.batch_none) begin
                    if (i_sts.out_free) begin
                        op = OP_EMPTY;
                    end
                end else if (!i_sts.inb_zero && i_sts.batch_full) begin
                    op = OP_NEXT;
                end else begin
                    n_state = S_CRD;
                end
            end
            S_CRD: begin
                op      = OP_CRD;
                n_state = S_CMD;
            end
            S_CMD: begin
                if (i_sts.out_free) begin
                    op      = OP_CMD;
                    n_state = S_TICK;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_op       = op;
    assign o_in_stall = (r_state != S_IDLE);
endmodule
